// ===== rtl/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types, microcode encodings and code tables for the prefix-code
// decoder: character to 5-bit code mapping and the codeword table.
// ----------------------------------------------------------------------------
package pcd_pkg;

    // widths of the pending store and its bit count
    localparam int unsigned BUF_W = 12;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned STEP_W = 2;
    localparam int unsigned NUM_CODES = 32;

    // datapath operation selected by the control word
    typedef enum logic [1:0] {
        OP_FETCH  = 2'd0,
        OP_DECODE = 2'd1,
        OP_FINISH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // jump condition of the control word
    typedef enum logic [1:0] {
        JC_NEVER    = 2'd0,
        JC_ALWAYS   = 2'd1,
        JC_NO_INPUT = 2'd2,
        JC_MATCHED  = 2'd3
    } jcond_t;

    // one microcode word
    typedef struct packed {
        op_t                op;
        jcond_t             jcond;
        logic [STEP_W-1:0]  target;
    } ctrl_word_t;

    // program addresses
    localparam logic [STEP_W-1:0] STEP_FETCH  = 2'd0;
    localparam logic [STEP_W-1:0] STEP_DECODE = 2'd1;
    localparam logic [STEP_W-1:0] STEP_FINISH = 2'd2;

    // datapath status back to the sequencer
    typedef struct packed {
        logic no_input;
        logic matched;
        logic stall;
    } dp_status_t;

    // one codeword: right-aligned code bits, length, ASCII symbol
    typedef struct packed {
        logic [7:0] code;
        logic [3:0] len;
        logic [6:0] sym;
    } codeword_t;

    localparam codeword_t CODE_TABLE [NUM_CODES] = '{
        '{8'h05, 4'd3, 7'h20}, '{8'h06, 4'd3, 7'h45}, '{8'h07, 4'd3, 7'h50},
        '{8'h05, 4'd4, 7'h43}, '{8'h01, 4'd4, 7'h44}, '{8'h07, 4'd4, 7'h49},
        '{8'h06, 4'd4, 7'h4B}, '{8'h08, 4'd4, 7'h52},
        '{8'h09, 4'd5, 7'h46}, '{8'h04, 4'd5, 7'h4C}, '{8'h05, 4'd5, 7'h4F},
        '{8'h06, 4'd5, 7'h53}, '{8'h07, 4'd5, 7'h54},
        '{8'h00, 4'd6, 7'h27}, '{8'h03, 4'd6, 7'h2C}, '{8'h11, 4'd6, 7'h2E},
        '{8'h01, 4'd6, 7'h3F}, '{8'h25, 4'd6, 7'h41}, '{8'h10, 4'd6, 7'h48},
        '{8'h02, 4'd6, 7'h57},
        '{8'h91, 4'd8, 7'h2D}, '{8'h9A, 4'd8, 7'h42}, '{8'h9B, 4'd8, 7'h47},
        '{8'h98, 4'd8, 7'h4A}, '{8'h99, 4'd8, 7'h4D}, '{8'h9E, 4'd8, 7'h4E},
        '{8'h9F, 4'd8, 7'h51}, '{8'h9C, 4'd8, 7'h55}, '{8'h9D, 4'd8, 7'h56},
        '{8'h92, 4'd8, 7'h58}, '{8'h93, 4'd8, 7'h59}, '{8'h90, 4'd8, 7'h5A}
    };

    // result of the character mapping
    typedef struct packed {
        logic       valid;
        logic [4:0] code;
    } char_code_t;

    // map a character to its 5-bit code
    function automatic char_code_t char_code(input logic [7:0] c);
        char_code_t res;
        logic [7:0] diff;
        res  = '0;
        diff = c - 8'h41;
        if (c >= 8'h41 && c <= 8'h5A) begin
            res.valid = 1'b1;
            res.code  = diff[4:0];
        end else begin
            res.valid = 1'b1;
            case (c)
                8'h20:   res.code = 5'd26;
                8'h2E:   res.code = 5'd27;
                8'h2C:   res.code = 5'd28;
                8'h2D:   res.code = 5'd29;
                8'h27:   res.code = 5'd30;
                8'h3F:   res.code = 5'd31;
                default: res.valid = 1'b0;
            endcase
        end
        return res;
    endfunction

    // codeword at the head of an 8-bit window; the code is complete so
    // exactly one entry matches
    function automatic codeword_t match_code(input logic [7:0] window);
        codeword_t  res;
        logic       found;
        logic [7:0] head;
        res   = CODE_TABLE[0];
        found = 1'b0;
        for (int i = 0; i < NUM_CODES; i++) begin
            head = window >> (4'd8 - CODE_TABLE[i].len);
            if (!found && head == CODE_TABLE[i].code) begin
                found = 1'b1;
                res   = CODE_TABLE[i];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/pcd_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// pcd_ucode_rom
// Control store of the decoder sequencer: one control word per step.
// ----------------------------------------------------------------------------
module pcd_ucode_rom (
    input  logic [pcd_pkg::STEP_W-1:0] step,
    output pcd_pkg::ctrl_word_t        ctrl
);

    // fetch waits for a transfer, decode repeats while codewords fit,
    // finish flushes the held symbol and returns to fetch
    always_comb begin
        unique case (step)
            pcd_pkg::STEP_FETCH: begin
                ctrl = '{pcd_pkg::OP_FETCH, pcd_pkg::JC_NO_INPUT, pcd_pkg::STEP_FETCH};
            end
            pcd_pkg::STEP_DECODE: begin
                ctrl = '{pcd_pkg::OP_DECODE, pcd_pkg::JC_MATCHED, pcd_pkg::STEP_DECODE};
            end
            pcd_pkg::STEP_FINISH: begin
                ctrl = '{pcd_pkg::OP_FINISH, pcd_pkg::JC_ALWAYS, pcd_pkg::STEP_FETCH};
            end
            default: begin
                ctrl = '{pcd_pkg::OP_NOP, pcd_pkg::JC_ALWAYS, pcd_pkg::STEP_FETCH};
            end
        endcase
    end

endmodule

// ===== rtl/pcd_datapath.sv =====
// ----------------------------------------------------------------------------
// pcd_datapath
// Pending bit store, codeword matcher, held symbol and output register,
// driven by the current control word.
// ----------------------------------------------------------------------------
module pcd_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pcd_pkg::ctrl_word_t    ctrl,
    output pcd_pkg::dp_status_t    status,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    logic [pcd_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [pcd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      last_reg, last_next;
    logic                      held_valid_reg, held_valid_next;
    logic [6:0]                held_char_reg, held_char_next;
    logic                      m_valid_reg, m_valid_next;
    logic [6:0]                m_char_reg, m_char_next;
    logic                      m_has_reg, m_has_next;
    logic                      m_eol_reg, m_eol_next;

    pcd_pkg::char_code_t       map;
    pcd_pkg::codeword_t        cw;
    logic [pcd_pkg::BUF_W+7:0] wide;
    logic [7:0]                window;
    logic                      fits;
    logic                      out_free;
    logic                      push;
    logic [6:0]                push_char;
    logic                      push_has;
    logic                      push_eol;

    // match the codeword at the head of the pending bits
    assign map    = pcd_pkg::char_code(s_tdata);
    assign wide   = {buf_reg, 8'h00} >> cnt_reg;
    assign window = wide[7:0];
    assign cw     = pcd_pkg::match_code(window);
    assign fits   = (cnt_reg >= 4'd3) && (cw.len <= cnt_reg);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (ctrl.op == pcd_pkg::OP_FETCH);

    // operation of the current step
    always_comb begin
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        held_valid_next = held_valid_reg;
        held_char_next  = held_char_reg;
        push            = 1'b0;
        push_char       = held_char_reg;
        push_has        = 1'b1;
        push_eol        = 1'b0;
        status          = '0;
        case (ctrl.op)
            pcd_pkg::OP_FETCH: begin
                status.no_input = !s_tvalid;
                if (s_tvalid) begin
                    last_next = s_tlast;
                    if (map.valid) begin
                        buf_next = {buf_reg[6:0], map.code};
                        cnt_next = cnt_reg + 4'd5;
                    end
                end
            end
            pcd_pkg::OP_DECODE: begin
                status.matched = fits;
                if (fits) begin
                    // the previous symbol is not the last one: send it
                    push         = held_valid_reg;
                    status.stall = held_valid_reg && !out_free;
                    if (!status.stall) begin
                        held_valid_next = 1'b1;
                        held_char_next  = cw.sym;
                        cnt_next        = cnt_reg - cw.len;
                        buf_next        = buf_reg & ~({pcd_pkg::BUF_W{1'b1}} << cnt_next);
                    end
                end
            end
            pcd_pkg::OP_FINISH: begin
                if (last_reg) begin
                    push      = 1'b1;
                    push_eol  = 1'b1;
                    push_has  = held_valid_reg;
                    push_char = held_valid_reg ? held_char_reg : 7'd0;
                end else begin
                    push = held_valid_reg;
                end
                status.stall = push && !out_free;
                if (!status.stall) begin
                    held_valid_next = 1'b0;
                    if (last_reg) begin
                        buf_next = '0;
                        cnt_next = '0;
                    end
                end
            end
            default: begin
                status = '0;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_has_next   = m_has_reg;
        m_eol_next   = m_eol_reg;
        if (push && !status.stall) begin
            m_valid_next = 1'b1;
            m_char_next  = push_char;
            m_has_next   = push_has;
            m_eol_next   = push_eol;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg        <= '0;
            cnt_reg        <= '0;
            last_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        held_char_reg <= held_char_next;
        m_char_reg    <= m_char_next;
        m_has_reg     <= m_has_next;
        m_eol_reg     <= m_eol_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_eol_reg;

endmodule

// ===== rtl/five_bit_to_prefix_code_decoder.sv =====
// ----------------------------------------------------------------------------
// five_bit_to_prefix_code_decoder
// Turns characters into 5-bit codes and decodes them against a fixed prefix
// code, giving one character per codeword found.
// ----------------------------------------------------------------------------
// One character is taken per pass of a three-step microprogram: a fetch step
// that takes the transfer and appends the 5-bit code, one decode step per
// codeword that fits plus one that finds none, and a finish step that sends
// the held symbol (with tlast at the end of a line, or a bare end marker when
// the last character of the line gave no codeword). A single shared matcher
// is reused by the decode step once per codeword. Downstream back-pressure
// stalls the decode and finish steps only while the output register is full.
module five_bit_to_prefix_code_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tlast,    // last_of_line
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] out_char, [7] zero fill
    output logic       m_tuser,    // has_char
    output logic       m_tlast     // end_of_line
);

    logic [pcd_pkg::STEP_W-1:0] step_reg, step_next;
    pcd_pkg::ctrl_word_t        ctrl;
    pcd_pkg::dp_status_t        status;
    logic                       take_jump;

    pcd_ucode_rom u_rom (
        .step (step_reg),
        .ctrl (ctrl)
    );

    pcd_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // jump condition
    always_comb begin
        case (ctrl.jcond)
            pcd_pkg::JC_ALWAYS:   take_jump = 1'b1;
            pcd_pkg::JC_NO_INPUT: take_jump = status.no_input;
            pcd_pkg::JC_MATCHED:  take_jump = status.matched;
            default:              take_jump = 1'b0;
        endcase
    end

    // step counter
    always_comb begin
        if (status.stall) begin
            step_next = step_reg;
        end else if (take_jump) begin
            step_next = ctrl.target;
        end else begin
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= pcd_pkg::STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/pcd_checker.sv =====
// ----------------------------------------------------------------------------
// pcd_checker
// Port-level checks for the prefix-code decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a result held back keeps its valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a result held back keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result payload changed while stalled");

    // a result without a character is only the bare end marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata == 8'h00))
        else $error("bare result is not an end marker");

    // decoded characters are 7-bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("out_char above 7 bits");

    // the block works on one character at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous character still decoding");

endmodule

bind five_bit_to_prefix_code_decoder pcd_checker u_pcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== dv/prefix_decode_checker.sv =====
// ----------------------------------------------------------------------------
// prefix_decode_checker
// Watches both stream channels of the prefix-code decoder, predicts the
// decoded characters of every input transfer and compares them, field by
// field and in order, with the result transfers.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prefix_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_char
    input  logic       s_tlast,    // last_of_line
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [6:0] out_char, [7] zero fill
    input  logic       m_tuser,    // has_char
    input  logic       m_tlast,    // end_of_line
    output int         error_count,
    output int         outstanding
);

    // one decoded character as it should leave the block
    typedef struct packed {
        logic [6:0] out_char;
        logic       has_char;
        logic       end_of_line;
    } decoded_char_t;

    localparam int MAX_PER_CHAR = 4;

    decoded_char_t expected_chars [$];

    // undecoded bits carried between characters, oldest bit highest
    logic [6:0] carry_bits;
    int         carry_count;

    initial begin
        error_count = 0;
        outstanding = 0;
        carry_bits  = '0;
        carry_count = 0;
    end

    // letters give 0..25, then space . , - ' ?
    function automatic logic char_to_code(input logic [7:0] c, output logic [4:0] code);
        code = '0;
        if (c >= "A" && c <= "Z") begin
            code = 5'(c - "A");
            return 1'b1;
        end
        case (c)
            " ":     code = 5'd26;
            ".":     code = 5'd27;
            ",":     code = 5'd28;
            "-":     code = 5'd29;
            "'":     code = 5'd30;
            "?":     code = 5'd31;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // codeword at the head of an 8-bit window; the code is complete and
    // prefix-free, so exactly one pattern fits
    function automatic void lookup_codeword(input logic [7:0] window,
                                            output int len, output logic [7:0] sym);
        casez (window)
            8'b101?????: begin len = 3; sym = " "; end
            8'b110?????: begin len = 3; sym = "E"; end
            8'b111?????: begin len = 3; sym = "P"; end
            8'b0101????: begin len = 4; sym = "C"; end
            8'b0001????: begin len = 4; sym = "D"; end
            8'b0111????: begin len = 4; sym = "I"; end
            8'b0110????: begin len = 4; sym = "K"; end
            8'b1000????: begin len = 4; sym = "R"; end
            8'b01001???: begin len = 5; sym = "F"; end
            8'b00100???: begin len = 5; sym = "L"; end
            8'b00101???: begin len = 5; sym = "O"; end
            8'b00110???: begin len = 5; sym = "S"; end
            8'b00111???: begin len = 5; sym = "T"; end
            8'b000000??: begin len = 6; sym = "'"; end
            8'b000011??: begin len = 6; sym = ","; end
            8'b010001??: begin len = 6; sym = "."; end
            8'b000001??: begin len = 6; sym = "?"; end
            8'b100101??: begin len = 6; sym = "A"; end
            8'b010000??: begin len = 6; sym = "H"; end
            8'b000010??: begin len = 6; sym = "W"; end
            8'b10010001: begin len = 8; sym = "-"; end
            8'b10011010: begin len = 8; sym = "B"; end
            8'b10011011: begin len = 8; sym = "G"; end
            8'b10011000: begin len = 8; sym = "J"; end
            8'b10011001: begin len = 8; sym = "M"; end
            8'b10011110: begin len = 8; sym = "N"; end
            8'b10011111: begin len = 8; sym = "Q"; end
            8'b10011100: begin len = 8; sym = "U"; end
            8'b10011101: begin len = 8; sym = "V"; end
            8'b10010010: begin len = 8; sym = "X"; end
            8'b10010011: begin len = 8; sym = "Y"; end
            default:     begin len = 8; sym = "Z"; end
        endcase
    endfunction

    // append the character's bits, decode greedily, queue the characters found
    function automatic void decode_character(input logic [7:0] c, input logic line_end);
        decoded_char_t found [MAX_PER_CHAR];
        logic [11:0]   acc;
        logic [4:0]    code;
        logic [7:0]    window;
        logic [7:0]    sym;
        int            nbits;
        int            len;
        int            k;
        logic          stop;
        acc   = {5'b0, carry_bits};
        nbits = carry_count;
        k     = 0;
        stop  = 1'b0;
        if (char_to_code(c, code)) begin
            acc   = (acc << 5) | {7'b0, code};
            nbits = nbits + 5;
        end
        while (!stop && nbits >= 3 && k < MAX_PER_CHAR) begin
            if (nbits >= 8)
                window = 8'(acc >> (nbits - 8));
            else
                window = 8'(acc << (8 - nbits));
            lookup_codeword(window, len, sym);
            if (len > nbits) begin
                stop = 1'b1;
            end else begin
                found[k] = '{out_char: sym[6:0], has_char: 1'b1, end_of_line: 1'b0};
                k = k + 1;
                nbits = nbits - len;
                acc = acc & ((12'd1 << nbits) - 12'd1);
            end
        end
        if (line_end) begin
            // leftover bits are dropped; a last character with nothing decoded still ends the line
            if (k == 0) begin
                found[0] = '{out_char: 7'd0, has_char: 1'b0, end_of_line: 1'b1};
                k = 1;
            end else begin
                found[k-1].end_of_line = 1'b1;
            end
            carry_bits  = '0;
            carry_count = 0;
        end else begin
            carry_bits  = acc[6:0];
            carry_count = nbits;
        end
        for (int i = 0; i < k; i++)
            expected_chars.insert(expected_chars.size(), found[i]);
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, exp_val, act_val);
            error_count++;
        end
    endfunction

    // input transfers feed the prediction, result transfers are compared
    always @(posedge aclk) begin : monitor
        decoded_char_t exp_char;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                decode_character(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected result transfer: tdata 'h%0h tuser %0b tlast %0b",
                           m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    check_field("out_char", int'(exp_char.out_char), int'(m_tdata[6:0]));
                    check_field("tdata fill", 0, int'(m_tdata[7]));
                    check_field("has_char", int'(exp_char.has_char), int'(m_tuser));
                    check_field("end_of_line", int'(exp_char.end_of_line), int'(m_tlast));
                end
            end
            outstanding = expected_chars.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the prefix-code decoder: sends directed and random lines of
// characters with random gaps and back-pressure, lets the checker compare
// every decoded character, and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 280;
    localparam int HOLD_AFTER   = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int NUM_DIRECTED = 23;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;    // [7:0] in_char
    logic       s_tlast  = 1'b0;  // last_of_line
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [6:0] out_char, [7] zero fill
    logic       m_tuser;          // has_char
    logic       m_tlast;          // end_of_line

    int   error_count;
    int   outstanding;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic no_gaps     = 1'b0;

    // the 32 characters that carry a code
    string coded_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";

    // {last_of_line, in_char}: unmapped bytes and line ends with nothing decoded,
    // leftover bits dropped, every punctuation code, the letter range edges
    logic [8:0] directed_items [NUM_DIRECTED] = '{
        {1'b1, 8'h00},
        {1'b0, 8'hFF}, {1'b0, 8'h80}, {1'b0, "a"}, {1'b1, "Z"},
        {1'b0, "Q"}, {1'b1, 8'h7F},
        {1'b0, "?"}, {1'b0, "'"}, {1'b0, "-"}, {1'b0, ","}, {1'b0, "."}, {1'b1, " "},
        {1'b0, "A"}, {1'b0, "M"}, {1'b0, "Y"}, {1'b0, "H"},
        {1'b0, 8'h40}, {1'b0, 8'h5B}, {1'b1, "A"},
        {1'b0, "E"}, {1'b0, "T"}, {1'b1, "?"}
    };

    five_bit_to_prefix_code_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    prefix_decode_checker checker_inst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // mostly coded characters, the rest any byte at all
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 85)
            return coded_chars[$urandom_range(0, 31)];
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // one input transfer; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial begin : receiver
        logic held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && items_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 80)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            m_tready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(20, 40)) @(negedge aclk);
            else
                repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
    end

    // reset, stimulus and verdict
    initial begin : stimulus
        int line_len;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_items[i])
            send_char(directed_items[i][7:0], directed_items[i][8]);

        // random lines, a quarter of them sent without gaps
        while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
            no_gaps  = ($urandom_range(0, 3) == 0);
            line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
                                                   : $urandom_range(1, 12);
            for (int j = 0; j < line_len; j++)
                send_char(pick_char(), j == line_len - 1);
        end
        s_tvalid <= 1'b0;
        no_gaps  = 1'b0;

        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
